### rtl/core/unix_time_to_iso8601_text_assert.svh
// Assertion macros for the Unix time to ISO 8601 text block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef UNIX_TIME_TO_ISO8601_TEXT_ASSERT_SVH
`define UNIX_TIME_TO_ISO8601_TEXT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while reset is high.
`define UIT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("uit assertion failed");
// Check a property on every rising edge, reset included.
`define UIT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("uit assertion failed");
`else
`define UIT_ASSERT(name, clk, rst, prop)
`define UIT_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### rtl/core/uit_pkg.sv
// Shared constants, types and helper functions for the Unix time to ISO 8601 text block.
// No dependencies; every module and interface file imports this package.
package uit_pkg;

  // Channel widths
  localparam int unsigned SecW    = 38;
  localparam int unsigned TextLen = 20;
  localparam int unsigned PosW    = 5;
  localparam logic [PosW-1:0] LastPos = PosW'(TextLen - 1);

  // Input saturates at 9999-12-31T23:59:59Z
  localparam logic [SecW-1:0] TopSeconds = 38'd253402300799;

  // 86400 = 128 * 675: drop seven bits, then divide by 675
  localparam int unsigned DayShift = 7;
  localparam int unsigned DayX     = SecW - DayShift;
  localparam logic [9:0]  DayOdd   = 10'd675;
  localparam logic [21:0] RecipDay = 22'((64'd1 << DayX) / 64'd675);

  localparam logic [21:0] EpochShift = 22'd719468;
  localparam logic [17:0] EraDays    = 18'd146097;
  localparam logic [17:0] EraLast    = 18'd146096;
  localparam logic [17:0] CentDays   = 18'd36524;
  localparam logic [10:0] QuadDays   = 11'd1460;
  localparam logic [8:0]  YearDays   = 9'd365;
  localparam logic [11:0] SecsHour   = 12'd3600;
  localparam logic [5:0]  SecsMin    = 6'd60;

  // Floor reciprocals: shift equals the numerator width, so the estimate
  // is the true quotient or one below it.
  localparam logic [4:0] RecipEra  = 5'((64'd1 << 22) / 64'd146097);
  localparam logic [5:0] RecipHour = 6'((64'd1 << 17) / 64'd3600);
  localparam logic [7:0] RecipQuad = 8'((64'd1 << 18) / 64'd1460);
  localparam logic [6:0] RecipMin  = 7'((64'd1 << 12) / 64'd60);
  localparam logic [9:0] RecipYear = 10'((64'd1 << 18) / 64'd365);

  // ASCII
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZ     = 8'h5A;

  typedef logic [TextLen-1:0][7:0] text_t;

  typedef struct packed {
    logic        valid;
    logic [21:0] z;     // days since 0000-03-01
    logic [16:0] tod;   // seconds into the day
  } split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic        valid;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    hms_t        hms;
  } date_t;

  typedef struct packed {
    logic  valid;
    text_t line;
  } textv_t;

  // First day of year of each month, counted from March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Tens digit in [7:4], ones digit in [3:0], for a value below 100
  function automatic logic [7:0] two_digits(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] r;
    t = '0;
    for (int k = 1; k <= 9; k++) begin
      t = t + 4'(v >= 7'(10 * k));
    end
    r = v - 7'(7'(t) * 7'd10);
    return {t, r[3:0]};
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return 8'(CharZero + 8'(d));
  endfunction

endpackage

### rtl/core/uit_stream_if.sv
// Valid/ready channel interfaces for the Unix time to ISO 8601 text block.
// Depends on uit_pkg for the payload widths.
interface uit_in_if import uit_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SecW-1:0] unix_seconds;

  modport source(output valid, output unix_seconds, input ready);
  modport sink(input valid, input unix_seconds, output ready);
endinterface

interface uit_out_if import uit_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [7:0]      text_char;
  logic [PosW-1:0] char_position;
  logic            last_char;

  modport source(output valid, output text_char, output char_position, output last_char,
                 input ready);
  modport sink(input valid, input text_char, input char_position, input last_char,
               output ready);
endinterface

### rtl/core/uit_sec_split.sv
// Two pipeline stages: saturate the seconds and split them into days and time of day.
// Depends on uit_pkg.
module uit_sec_split import uit_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [SecW-1:0] unix_seconds,
  output split_t          split
);

  logic              v1;
  logic [DayX-1:0]   s1_x;
  logic [6:0]        s1_lo;
  logic [21:0]       s1_q;

  logic              v2;
  logic [21:0]       s2_z;
  logic [16:0]       s2_tod;

  logic [SecW-1:0]   sat;
  logic [52:0]       qprod;
  logic [DayX-1:0]   qmul;
  logic [10:0]       r;
  logic [21:0]       days;
  logic [9:0]        rr;

  // Stage 1: clamp, drop the power-of-two part of 86400, estimate days
  always_comb begin
    sat   = (unix_seconds > TopSeconds) ? TopSeconds : unix_seconds;
    qprod = 53'(sat[SecW-1:DayShift]) * 53'(RecipDay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x  <= sat[SecW-1:DayShift];
      s1_lo <= sat[DayShift-1:0];
      s1_q  <= qprod[52:31];
    end
  end

  // Stage 2: correct the estimate, rebuild time of day, shift the day base
  always_comb begin
    qmul = s1_x - DayX'(DayX'(s1_q) * DayX'(DayOdd));
    r    = qmul[10:0];
    if (r >= 11'(DayOdd)) begin
      days = s1_q + 22'd1;
      rr   = 10'(r - 11'(DayOdd));
    end else begin
      days = s1_q;
      rr   = r[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_z   <= days + EpochShift;
      s2_tod <= {rr, s1_lo};
    end
  end

  assign split = '{valid: v2, z: s2_z, tod: s2_tod};

endmodule

### rtl/core/uit_civil_date.sv
// Nine pipeline stages: day count to civil year, month, day; time of day to h:m:s.
// Depends on uit_pkg.
module uit_civil_date import uit_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  split_t split,
  output date_t  date
);

  logic [8:0]  vld;

  // stage 3
  logic [21:0] s3_z;
  logic [4:0]  s3_era;
  logic [16:0] s3_tod;
  logic [4:0]  s3_hr;
  // stage 4
  logic [4:0]  s4_era;
  logic [17:0] s4_doe;
  logic [4:0]  s4_hour;
  logic [11:0] s4_rt;
  // stage 5
  logic [4:0]  s5_era;
  logic [17:0] s5_doe;
  logic [6:0]  s5_a;
  logic [2:0]  s5_b;
  logic        s5_c;
  logic [4:0]  s5_hour;
  logic [11:0] s5_rt;
  logic [5:0]  s5_min;
  // stage 6
  logic [4:0]  s6_era;
  logic [17:0] s6_doe;
  logic [17:0] s6_y;
  hms_t        s6_hms;
  // stage 7
  logic [4:0]  s7_era;
  logic [17:0] s7_doe;
  logic [17:0] s7_y;
  logic [8:0]  s7_yoe;
  hms_t        s7_hms;
  // stage 8
  logic [4:0]  s8_era;
  logic [17:0] s8_doe;
  logic [8:0]  s8_yoe;
  hms_t        s8_hms;
  // stage 9
  logic [4:0]  s9_era;
  logic [8:0]  s9_yoe;
  logic [8:0]  s9_doy;
  hms_t        s9_hms;
  // stage 10
  logic [4:0]  s10_era;
  logic [8:0]  s10_yoe;
  logic [8:0]  s10_doy;
  logic [3:0]  s10_mp;
  hms_t        s10_hms;
  // stage 11
  logic [13:0] s11_year;
  logic [3:0]  s11_month;
  logic [4:0]  s11_day;
  hms_t        s11_hms;

  logic [26:0] era_prod;
  logic [22:0] hr_prod;
  logic [21:0] rd;
  logic [4:0]  era_c;
  logic [17:0] doe_c;
  logic [16:0] rt_full;
  logic [4:0]  hour_c;
  logic [11:0] rt_c;
  logic [25:0] a_prod;
  logic [2:0]  b_cnt;
  logic [18:0] min_prod;
  logic [17:0] ra;
  logic [6:0]  a_c;
  logic [11:0] rm;
  logic [5:0]  min_c;
  logic [5:0]  sec_c;
  logic [27:0] yoe_prod;
  logic [17:0] ry;
  logic [8:0]  yoe_c;
  logic [1:0]  cent;
  logic [17:0] yday_base;
  logic [3:0]  mp_c;
  logic [3:0]  month_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[7:0], split.valid};
    end
  end

  always_comb begin
    // stage 3: estimate era and hour
    era_prod = 27'(split.z) * 27'(RecipEra);
    hr_prod  = 23'(split.tod) * 23'(RecipHour);

    // stage 4: correct era and hour, form day of era and seconds into the hour
    rd = s3_z - 22'(22'(s3_era) * 22'(EraDays));
    if (rd >= 22'(EraDays)) begin
      era_c = s3_era + 5'd1;
      doe_c = 18'(rd - 22'(EraDays));
    end else begin
      era_c = s3_era;
      doe_c = rd[17:0];
    end
    rt_full = s3_tod - 17'(17'(s3_hr) * 17'(SecsHour));
    if (rt_full >= 17'(SecsHour)) begin
      hour_c = s3_hr + 5'd1;
      rt_c   = 12'(rt_full - 17'(SecsHour));
    end else begin
      hour_c = s3_hr;
      rt_c   = rt_full[11:0];
    end

    // stage 5: estimate four-year groups and minutes, count centuries
    a_prod = 26'(s4_doe) * 26'(RecipQuad);
    b_cnt  = '0;
    for (int k = 1; k <= 4; k++) begin
      b_cnt = b_cnt + 3'(s4_doe >= 18'(k * CentDays));
    end
    min_prod = 19'(s4_rt) * 19'(RecipMin);

    // stage 6: correct the estimates, form the leap-free day count
    ra  = s5_doe - 18'(18'(s5_a) * 18'(QuadDays));
    a_c = s5_a + 7'(ra >= 18'(QuadDays));
    rm  = s5_rt - 12'(12'(s5_min) * 12'(SecsMin));
    if (rm >= 12'(SecsMin)) begin
      min_c = s5_min + 6'd1;
      sec_c = 6'(rm - 12'(SecsMin));
    end else begin
      min_c = s5_min;
      sec_c = rm[5:0];
    end

    // stage 7: estimate year of era
    yoe_prod = 28'(s6_y) * 28'(RecipYear);

    // stage 8: correct year of era
    ry    = s7_y - 18'(18'(s7_yoe) * 18'(YearDays));
    yoe_c = s7_yoe + 9'(ry >= 18'(YearDays));

    // stage 9: day of the March-based year
    cent = '0;
    for (int k = 1; k <= 3; k++) begin
      cent = cent + 2'(s8_yoe >= 9'(k * 100));
    end
    yday_base = 18'(18'(s8_yoe) * 18'(YearDays)) + 18'(s8_yoe >> 2) - 18'(cent);

    // stage 10: month counted from March
    mp_c = '0;
    for (int k = 1; k <= 11; k++) begin
      mp_c = mp_c + 4'(s9_doy >= month_start(4'(k)));
    end

    // stage 11: civil month
    month_c = (s10_mp < 4'd10) ? s10_mp + 4'd3 : s10_mp - 4'd9;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_z    <= split.z;
      s3_era  <= era_prod[26:22];
      s3_tod  <= split.tod;
      s3_hr   <= hr_prod[21:17];

      s4_era  <= era_c;
      s4_doe  <= doe_c;
      s4_hour <= hour_c;
      s4_rt   <= rt_c;

      s5_era  <= s4_era;
      s5_doe  <= s4_doe;
      s5_a    <= a_prod[24:18];
      s5_b    <= b_cnt;
      s5_c    <= (s4_doe == EraLast);
      s5_hour <= s4_hour;
      s5_rt   <= s4_rt;
      s5_min  <= min_prod[17:12];

      s6_era  <= s5_era;
      s6_doe  <= s5_doe;
      s6_y    <= s5_doe - 18'(a_c) + 18'(s5_b) - 18'(s5_c);
      s6_hms  <= '{hour: s5_hour, minute: min_c, second: sec_c};

      s7_era  <= s6_era;
      s7_doe  <= s6_doe;
      s7_y    <= s6_y;
      s7_yoe  <= yoe_prod[26:18];
      s7_hms  <= s6_hms;

      s8_era  <= s7_era;
      s8_doe  <= s7_doe;
      s8_yoe  <= yoe_c;
      s8_hms  <= s7_hms;

      s9_era  <= s8_era;
      s9_yoe  <= s8_yoe;
      s9_doy  <= 9'(s8_doe - yday_base);
      s9_hms  <= s8_hms;

      s10_era <= s9_era;
      s10_yoe <= s9_yoe;
      s10_doy <= s9_doy;
      s10_mp  <= mp_c;
      s10_hms <= s9_hms;

      s11_day   <= 5'(s10_doy - month_start(s10_mp) + 9'd1);
      s11_month <= month_c;
      s11_year  <= 14'(s10_yoe) + 14'(14'(s10_era) * 14'd400) + 14'(month_c <= 4'd2);
      s11_hms   <= s10_hms;
    end
  end

  assign date = '{valid: vld[8], year: s11_year, month: s11_month, day: s11_day,
                  hms: s11_hms};

endmodule

### rtl/core/uit_text_fmt.sv
// Three pipeline stages: split the date and time fields into decimal digits and
// assemble the 20 ASCII characters. Depends on uit_pkg.
module uit_text_fmt import uit_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  date_t  date,
  output textv_t text
);

  logic [2:0]  vld;

  logic [3:0]  s12_th;
  logic [9:0]  s12_rem;
  date_t       s12_date;

  logic [3:0]  s13_th;
  logic [3:0]  s13_hu;
  logic [6:0]  s13_rem;
  date_t       s13_date;

  text_t       s14_line;

  logic [3:0]  th_c;
  logic [3:0]  hu_c;
  logic [7:0]  yy;
  logic [7:0]  mo;
  logic [7:0]  dd;
  logic [7:0]  hh;
  logic [7:0]  mi;
  logic [7:0]  ss;
  text_t       line;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], date.valid};
    end
  end

  always_comb begin
    th_c = '0;
    for (int k = 1; k <= 9; k++) begin
      th_c = th_c + 4'(date.year >= 14'(k * 1000));
    end
    hu_c = '0;
    for (int k = 1; k <= 9; k++) begin
      hu_c = hu_c + 4'(s12_rem >= 10'(k * 100));
    end

    yy = two_digits(s13_rem);
    mo = two_digits(7'(s13_date.month));
    dd = two_digits(7'(s13_date.day));
    hh = two_digits(7'(s13_date.hms.hour));
    mi = two_digits(7'(s13_date.hms.minute));
    ss = two_digits(7'(s13_date.hms.second));

    line[0]  = digit_char(s13_th);
    line[1]  = digit_char(s13_hu);
    line[2]  = digit_char(yy[7:4]);
    line[3]  = digit_char(yy[3:0]);
    line[4]  = CharDash;
    line[5]  = digit_char(mo[7:4]);
    line[6]  = digit_char(mo[3:0]);
    line[7]  = CharDash;
    line[8]  = digit_char(dd[7:4]);
    line[9]  = digit_char(dd[3:0]);
    line[10] = CharT;
    line[11] = digit_char(hh[7:4]);
    line[12] = digit_char(hh[3:0]);
    line[13] = CharColon;
    line[14] = digit_char(mi[7:4]);
    line[15] = digit_char(mi[3:0]);
    line[16] = CharColon;
    line[17] = digit_char(ss[7:4]);
    line[18] = digit_char(ss[3:0]);
    line[19] = CharZ;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_th   <= th_c;
      s12_rem  <= 10'(date.year - 14'(14'(th_c) * 14'd1000));
      s12_date <= date;

      s13_th   <= s12_th;
      s13_hu   <= hu_c;
      s13_rem  <= 7'(s12_rem - 10'(10'(hu_c) * 10'd100));
      s13_date <= s12_date;

      s14_line <= line;
    end
  end

  assign text = '{valid: vld[2], line: s14_line};

endmodule

### rtl/core/uit_serializer.sv
// Output stage: holds one finished timestamp and sends it one character per request.
// Depends on uit_pkg, uit_stream_if and the assertion macro header.
`include "unix_time_to_iso8601_text_assert.svh"
module uit_serializer import uit_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  textv_t text,
  output logic   take,
  uit_out_if.source chars
);

  logic            busy;
  logic [PosW-1:0] idx;
  text_t           line;

  logic            fire;
  logic            done;

  assign fire = busy && chars.ready;
  assign done = fire && (idx == LastPos);
  assign take = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      busy <= text.valid;
      idx  <= '0;
    end else if (fire) begin
      idx  <= idx + PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take && text.valid) begin
      line <= text.line;
    end
  end

  assign chars.valid         = busy;
  assign chars.text_char     = line[idx];
  assign chars.char_position = idx;
  assign chars.last_char     = (idx == LastPos);

  `UIT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !busy)
  `UIT_ASSERT(a_step, clk, rst, fire && (idx != LastPos) |=> busy && (idx == $past(idx) + PosW'(1)))
  `UIT_ASSERT(a_start_pos, clk, rst, $rose(busy) |-> idx == '0)
  `UIT_ASSERT(a_hold, clk, rst, busy && !chars.ready |=> busy && $stable(idx) && $stable(line))

endmodule

### rtl/core/unix_time_to_iso8601_text.sv
// Top level of the Unix time to ISO 8601 UTC text block.
// Depends on uit_pkg, uit_stream_if, uit_sec_split, uit_civil_date, uit_text_fmt
// and uit_serializer.
// Usage:
//   seconds : request channel, one Unix second count (38 bits) per request.
//   chars   : result channel, 20 requests per timestamp, YYYY-MM-DDTHH:MM:SSZ,
//             each with its position 0..19; last_char marks the closing 'Z'.
//   Counts above 9999-12-31T23:59:59Z are clamped to that instant.
// Timing:
//   A 14-stage pipeline (2 stages of day split, 9 of calendar math, 3 of digit
//   formatting) feeds a one-timestamp output buffer. The buffer register takes
//   a finished timestamp from the last stage and presents its first character;
//   while chars.ready is high the characters leave one per cycle. Sustained
//   throughput is set by the single character-wide output port; up to 14 further
//   requests sit in the pipeline meanwhile.
// Stall:
//   While the buffer is busy the pipeline holds once its last stage is occupied,
//   and seconds.ready drops with it; nothing is lost or sent twice. A new
//   timestamp loads in the same cycle the last character leaves.
// Reset: synchronous, active high; clears the valid bits and the character index.
module unix_time_to_iso8601_text import uit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  uit_in_if.sink    seconds,
  uit_out_if.source chars
);

  logic   adv;     // advance every pipeline stage this cycle
  logic   take;    // output buffer accepts a finished timestamp
  split_t split;
  date_t  date;
  textv_t text;

  // Move while the last stage is empty or its timestamp is being taken
  assign adv           = !text.valid || take;
  assign seconds.ready = adv;

  uit_sec_split u_split (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (seconds.valid),
    .unix_seconds (seconds.unix_seconds),
    .split        (split)
  );

  uit_civil_date u_date (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .split (split),
    .date  (date)
  );

  uit_text_fmt u_fmt (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .date (date),
    .text (text)
  );

  uit_serializer u_ser (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .take  (take),
    .chars (chars)
  );

endmodule
